// ===== hdl/fcr_pkg.sv =====
// Package with the widths, codes and shared types of the filled-circle rasterizer.
`default_nettype none
package fcr_pkg;

	localparam int COORD_BITS = 12;
	localparam int RAD_W      = COORD_BITS - 1;
	localparam int POS_W      = COORD_BITS + 2;
	localparam int COLOR_W    = 32;
	localparam int OFF_W      = 26;

	localparam int SCR_W      = 13;
	localparam int STRIDE_W   = 15;
	localparam int BPP_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	localparam int SQ_W       = 2 * POS_W;
	localparam int RSQ_W      = 2 * RAD_W;
	localparam int UPOS_W     = POS_W - 1;
	localparam int YOFF_W     = UPOS_W + STRIDE_W;
	localparam int XOFF_W     = UPOS_W + BPP_W;
	localparam int OSUM_W     = ((YOFF_W > OFF_W) ? YOFF_W : OFF_W) + 1;
	localparam int CMP_W      = ((UPOS_W > SCR_W) ? UPOS_W : SCR_W) + 1;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIX = 2'd3;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	typedef struct packed {
		logic [SCR_W-1:0]    screen_width;
		logic [SCR_W-1:0]    screen_height;
		logic [STRIDE_W-1:0] line_stride;
		logic [BPP_W-1:0]    bytes_per_pixel;
	} cfg_t;

	typedef struct packed {
		logic                    idle;
		logic signed [POS_W-1:0] col;
		logic signed [POS_W-1:0] row;
		logic [COORD_BITS-1:0]   cx;
		logic [COORD_BITS-1:0]   cy;
		logic [RAD_W-1:0]        rad;
		logic [COLOR_W-1:0]      color;
		logic                    last;
	} pos_item_t;

endpackage
`default_nettype wire

// ===== hdl/fcr_front.sv =====
// Front end: accepts command items, walks the bounding box and issues position items.
`default_nettype none
module fcr_front
	import fcr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  cmd,
	input  wire logic [COORD_BITS-1:0] center_x,
	input  wire logic [COORD_BITS-1:0] center_y,
	input  wire logic [RAD_W-1:0]      circle_radius,
	input  wire logic [COLOR_W-1:0]    fill_color,
	output logic                       push,
	output pos_item_t                  push_item,
	input  wire logic                  q_full
);

	logic [COORD_BITS-1:0]   cx_q, cy_q;
	logic [RAD_W-1:0]        rad_q;
	logic [COLOR_W-1:0]      color_q;
	logic signed [POS_W-1:0] col_q, row_q;
	logic                    active_q;

	logic [COORD_BITS-1:0]   cx_n, cy_n;
	logic [RAD_W-1:0]        rad_n;
	logic [COLOR_W-1:0]      color_n;
	logic signed [POS_W-1:0] col_n, row_n;
	logic                    active_n;
	logic                    idle_n;
	logic signed [POS_W-1:0] lo_x, lo_y, hi_x, hi_y, hi_y_q;
	logic                    cur_last;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		lo_x     = $signed({2'b00, center_x}) - $signed({3'b000, circle_radius});
		lo_y     = $signed({2'b00, center_y}) - $signed({3'b000, circle_radius});
		hi_y_q   = $signed({2'b00, cy_q}) + $signed({3'b000, rad_q});
		cur_last = (col_q == ($signed({2'b00, cx_q}) + $signed({3'b000, rad_q})))
			&& (row_q == hi_y_q);
		cx_n     = cx_q;
		cy_n     = cy_q;
		rad_n    = rad_q;
		color_n  = color_q;
		col_n    = col_q;
		row_n    = row_q;
		active_n = active_q;
		idle_n   = 1'b0;
		if (cmd == CMD_START) begin
			cx_n     = center_x;
			cy_n     = center_y;
			rad_n    = circle_radius;
			color_n  = fill_color;
			col_n    = lo_x;
			row_n    = lo_y;
			active_n = 1'b1;
		end else if (!active_q) begin
			idle_n = 1'b1;
		end else if (cur_last) begin
			active_n = 1'b0;
			col_n    = '0;
			row_n    = '0;
			idle_n   = 1'b1;
		end else if (row_q >= hi_y_q) begin
			row_n = $signed({2'b00, cy_q}) - $signed({3'b000, rad_q});
			col_n = col_q + $signed(POS_W'(1));
		end else begin
			row_n = row_q + $signed(POS_W'(1));
		end
		hi_x = $signed({2'b00, cx_n}) + $signed({3'b000, rad_n});
		hi_y = $signed({2'b00, cy_n}) + $signed({3'b000, rad_n});
		push_item.idle  = idle_n;
		push_item.col   = col_n;
		push_item.row   = row_n;
		push_item.cx    = cx_n;
		push_item.cy    = cy_n;
		push_item.rad   = rad_n;
		push_item.color = color_n;
		push_item.last  = idle_n || ((col_n == hi_x) && (row_n == hi_y));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			rad_q    <= '0;
			color_q  <= '0;
			col_q    <= '0;
			row_q    <= '0;
			active_q <= 1'b0;
		end else if (push) begin
			cx_q     <= cx_n;
			cy_q     <= cy_n;
			rad_q    <= rad_n;
			color_q  <= color_n;
			col_q    <= col_n;
			row_q    <= row_n;
			active_q <= active_n;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/fcr_queue.sv =====
// Two-entry queue that carries position items from the front end to the back end.
`default_nettype none
module fcr_queue
	import fcr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  pos_item_t      push_item,
	output logic           full,
	input  wire logic      pop,
	output logic           q_valid,
	output pos_item_t      head
);

	pos_item_t  mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign head    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/fcr_back.sv =====
// Back end: inside test, screen clip and byte offset in two stages with a registered output.
`default_nettype none
module fcr_back
	import fcr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  cfg_t                     cfg,
	input  wire logic                q_valid,
	input  pos_item_t                head,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [POS_W-1:0]  pixel_x,
	output logic signed [POS_W-1:0]  pixel_y,
	output logic                     write_enable,
	output logic [OFF_W-1:0]         byte_offset,
	output logic [COLOR_W-1:0]       pixel_color,
	output logic                     last_position
);

	logic                    en;
	logic                    valid_s1, valid_s2;
	logic                    idle_s1, last_s1, on_s1;
	logic signed [POS_W-1:0] col_s1, row_s1;
	logic [COLOR_W-1:0]      color_s1;
	logic signed [SQ_W-1:0]  dx2_s1, dy2_s1;
	logic [RSQ_W-1:0]        r2_s1;
	logic [YOFF_W-1:0]       yoff_s1;
	logic [XOFF_W-1:0]       xoff_s1;

	logic signed [POS_W-1:0] dx, dy;
	logic [UPOS_W-1:0]       col_u, row_u;
	logic                    on_screen;
	logic [SQ_W:0]           dist_sq;
	logic                    in_circle, we;
	logic [OSUM_W-1:0]       off_sum;

	assign en  = !valid_s2 || out_ready;
	assign pop = en && q_valid;

	always_comb begin
		dx    = head.col - $signed({2'b00, head.cx});
		dy    = head.row - $signed({2'b00, head.cy});
		col_u = head.col[UPOS_W-1:0];
		row_u = head.row[UPOS_W-1:0];
		on_screen = !head.col[POS_W-1] && !head.row[POS_W-1]
			&& ({{(CMP_W-UPOS_W){1'b0}}, col_u} < {{(CMP_W-SCR_W){1'b0}}, cfg.screen_width})
			&& ({{(CMP_W-UPOS_W){1'b0}}, row_u} < {{(CMP_W-SCR_W){1'b0}}, cfg.screen_height});
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			idle_s1  <= head.idle;
			last_s1  <= head.last;
			col_s1   <= head.col;
			row_s1   <= head.row;
			color_s1 <= head.color;
			on_s1    <= on_screen;
			dx2_s1   <= dx * dx;
			dy2_s1   <= dy * dy;
			r2_s1    <= head.rad * head.rad;
			yoff_s1  <= row_u * cfg.line_stride;
			xoff_s1  <= col_u * cfg.bytes_per_pixel;
		end
	end

	always_comb begin
		dist_sq   = {1'b0, dx2_s1} + {1'b0, dy2_s1};
		in_circle = dist_sq <= {{(SQ_W+1-RSQ_W){1'b0}}, r2_s1};
		we        = in_circle && on_s1 && !idle_s1;
		off_sum   = {{(OSUM_W-YOFF_W){1'b0}}, yoff_s1} + {{(OSUM_W-XOFF_W){1'b0}}, xoff_s1};
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			pixel_x       <= idle_s1 ? '0 : col_s1;
			pixel_y       <= idle_s1 ? '0 : row_s1;
			write_enable  <= we;
			byte_offset   <= we ? off_sum[OFF_W-1:0] : '0;
			pixel_color   <= idle_s1 ? '0 : color_s1;
			last_position <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= q_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign out_valid = valid_s2;

endmodule
`default_nettype wire

// ===== hdl/filled_circle_rasterizer.sv =====
// Top level of the filled-circle rasterizer: configuration registers, front end, queue, back end.
// An accepted item is held in the queue, then in the back-end stage one and output registers.
// Throughput: one item per cycle, sustained; the back end stalls only while the output waits.
// When the output stalls in steady flow, the two-entry queue takes one more item, then holds off.
// Reset is asynchronous and active low: the scan goes idle, the queue and stages empty,
// and the registers return to 800, 480, 3200 and 4.
`default_nettype none
module filled_circle_rasterizer
	import fcr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  cmd,
	input  wire logic [COORD_BITS-1:0] center_x,
	input  wire logic [COORD_BITS-1:0] center_y,
	input  wire logic [RAD_W-1:0]      circle_radius,
	input  wire logic [COLOR_W-1:0]    fill_color,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [POS_W-1:0]    pixel_x,
	output logic signed [POS_W-1:0]    pixel_y,
	output logic                       write_enable,
	output logic [OFF_W-1:0]           byte_offset,
	output logic [COLOR_W-1:0]         pixel_color,
	output logic                       last_position
);

	cfg_t      cfg_q;
	logic      push, q_full, pop, q_valid;
	pos_item_t push_item, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width    <= SCR_W'(800);
			cfg_q.screen_height   <= SCR_W'(480);
			cfg_q.line_stride     <= STRIDE_W'(3200);
			cfg_q.bytes_per_pixel <= BPP_W'(4);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  cfg_q.screen_width    <= cfg_data[SCR_W-1:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height   <= cfg_data[SCR_W-1:0];
				REG_LINE_STRIDE:   cfg_q.line_stride     <= cfg_data[STRIDE_W-1:0];
				REG_BYTES_PER_PIX: cfg_q.bytes_per_pixel <= cfg_data[BPP_W-1:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	fcr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.center_x      (center_x),
		.center_y      (center_y),
		.circle_radius (circle_radius),
		.fill_color    (fill_color),
		.push          (push),
		.push_item     (push_item),
		.q_full        (q_full)
	);

	fcr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.head      (head)
	);

	fcr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.write_enable  (write_enable),
		.byte_offset   (byte_offset),
		.pixel_color   (pixel_color),
		.last_position (last_position)
	);

endmodule
`default_nettype wire

// ===== hdl/fcr_checker.sv =====
// Port-level assertions for the filled-circle rasterizer and the bind that attaches them.
`default_nettype none
module fcr_checker
	import fcr_pkg::*;
(
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic signed [POS_W-1:0] pixel_x,
	input wire logic signed [POS_W-1:0] pixel_y,
	input wire logic                    write_enable,
	input wire logic [OFF_W-1:0]        byte_offset
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(byte_offset))
		else $error("Output item changed while stalled.");

	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> byte_offset == '0)
		else $error("Nonzero byte offset without write enable.");

	a_write_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_enable |-> !pixel_x[POS_W-1] && !pixel_y[POS_W-1])
		else $error("Write enabled at a negative position.");

endmodule

bind filled_circle_rasterizer fcr_checker u_fcr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.pixel_x      (pixel_x),
	.pixel_y      (pixel_y),
	.write_enable (write_enable),
	.byte_offset  (byte_offset)
);
`default_nettype wire
